// ----- rtl/adpcm4_pkg.sv -----
// adpcm4_pkg: shared types, constants and the step gain table of the adpcm4 decoder
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps

package adpcm4_pkg;

    localparam int unsigned CodeByteW = 8;
    localparam int unsigned NibW      = 4;
    localparam int unsigned SampleW   = 8;
    localparam int unsigned StepCfgW  = 16;
    localparam int unsigned AccW      = 32;
    localparam int unsigned GainW     = 8;
    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned CfgDataW  = 16;

    localparam logic [CfgIdxW-1:0] CFG_SAMPLE_MIN   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_SAMPLE_MAX   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_INITIAL_STEP = 2'd2;

    localparam logic [SampleW-1:0]  SampleMinReset   = 8'h80;
    localparam logic [SampleW-1:0]  SampleMaxReset   = 8'h7F;
    localparam logic [StepCfgW-1:0] InitialStepReset = 16'h0800;

    localparam logic [AccW-1:0] StepRound = 32'd127;
    localparam int unsigned     StepShift = 7;
    localparam int unsigned     TapLeak   = 3;
    localparam int unsigned     TapOut    = 8;

    // command word from the controller to the datapath
    typedef struct packed {
        logic load;     // latch request, apply restart
        logic mul;      // tap update and products for one nibble
        logic upd;      // prediction, history shift, step adapt, sample capture
        logic nib_sel;  // 0 low nibble, 1 high nibble
        logic emit;     // move finished samples into the output register
    } t_dp_cmd;

    function automatic logic [GainW-1:0] f_gain(input logic [NibW-1:0] code);
        logic [GainW-1:0] g;
        unique case (code)
            4'd0:    g = 8'd112;
            4'd1:    g = 8'd128;
            4'd2:    g = 8'd128;
            4'd3:    g = 8'd128;
            4'd4:    g = 8'd128;
            4'd5:    g = 8'd136;
            4'd6:    g = 8'd136;
            4'd7:    g = 8'd192;
            4'd8:    g = 8'd192;
            4'd9:    g = 8'd192;
            4'd10:   g = 8'd136;
            4'd11:   g = 8'd136;
            4'd12:   g = 8'd128;
            4'd13:   g = 8'd128;
            4'd14:   g = 8'd128;
            default: g = 8'd128;
        endcase
        return g;
    endfunction

endpackage

// ----- rtl/adpcm4_in_if.sv -----
// adpcm4_in_if: request channel carrying one code byte with its flags
// depends on adpcm4_pkg
`timescale 1ns / 1ps

interface adpcm4_in_if
    import adpcm4_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CodeByteW-1:0] code_byte;
    logic                 restart;
    logic                 final_byte;

    modport source (output valid, code_byte, restart, final_byte, input ready);
    modport sink   (input valid, code_byte, restart, final_byte, output ready);
endinterface

// ----- rtl/adpcm4_out_if.sv -----
// adpcm4_out_if: result channel carrying two decoded samples and the end marker
// depends on adpcm4_pkg
`timescale 1ns / 1ps

interface adpcm4_out_if
    import adpcm4_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [SampleW-1:0] sample_first;
    logic signed [SampleW-1:0] sample_second;
    logic                      final_res;

    modport source (output valid, sample_first, sample_second, final_res, input ready);
    modport sink   (input valid, sample_first, sample_second, final_res, output ready);
endinterface

// ----- rtl/adpcm4_dp.sv -----
// adpcm4_dp: decoder datapath, predictor state, config registers and output payload
// depends on adpcm4_pkg; driven by adpcm4_ctrl through t_dp_cmd
`timescale 1ns / 1ps

module adpcm4_dp
    import adpcm4_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  logic [CodeByteW-1:0]      i_code_byte,
    input  logic                      i_restart,
    input  logic                      i_final_byte,
    input  logic                      i_cfg_we,
    input  logic [CfgIdxW-1:0]        i_cfg_idx,
    input  logic [CfgDataW-1:0]       i_cfg_data,
    output logic signed [SampleW-1:0] o_sample_first,
    output logic signed [SampleW-1:0] o_sample_second,
    output logic                      o_final_res
);

    logic [SampleW-1:0]  r_cfg_min;
    logic [SampleW-1:0]  r_cfg_max;
    logic [StepCfgW-1:0] r_cfg_step;

    logic [AccW-1:0] r_h1, r_h2, r_tap, r_step;
    logic [AccW-1:0] r_prod_pred, r_prod_step;
    logic [CodeByteW-1:0] r_byte;
    logic r_final;
    logic [SampleW-1:0] r_s0, r_s1;

    logic [NibW-1:0]             w_code;
    logic signed [AccW+NibW-1:0] w_pp_full;
    logic [AccW+GainW-1:0]       w_ps_full;
    logic [AccW-1:0]             w_tap_next;
    logic [AccW-1:0]             w_pred;
    logic [AccW-1:0]             w_step_sum;
    logic [AccW-1:0]             w_step_next;
    logic signed [AccW-TapOut-1:0] w_tap_hi;
    logic signed [AccW-TapOut-1:0] w_lo, w_hi;
    logic [SampleW-1:0]          w_sample;

    assign w_code    = i_cmd.nib_sel ? r_byte[CodeByteW-1:NibW] : r_byte[NibW-1:0];
    assign w_pp_full = $signed(r_step) * $signed(w_code);
    assign w_ps_full = r_step * f_gain(w_code);
    assign w_tap_next = r_h2 + r_tap - AccW'($signed(r_tap) >>> TapLeak);

    assign w_pred      = r_prod_pred + r_h1 - r_h2;
    assign w_step_sum  = r_prod_step + StepRound;
    assign w_step_next = AccW'($signed(w_step_sum) >>> StepShift);

    // sample: tap >> 8 clamped, min bound checked first
    assign w_tap_hi = r_tap[AccW-1:TapOut];
    assign w_lo     = (AccW-TapOut)'($signed(r_cfg_min));
    assign w_hi     = (AccW-TapOut)'($signed(r_cfg_max));

    always_comb begin
        priority if (w_tap_hi < w_lo) begin
            w_sample = r_cfg_min;
        end else if (w_tap_hi > w_hi) begin
            w_sample = r_cfg_max;
        end else begin
            w_sample = w_tap_hi[SampleW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_min  <= SampleMinReset;
            r_cfg_max  <= SampleMaxReset;
            r_cfg_step <= InitialStepReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SAMPLE_MIN:   r_cfg_min  <= i_cfg_data[SampleW-1:0];
                CFG_SAMPLE_MAX:   r_cfg_max  <= i_cfg_data[SampleW-1:0];
                CFG_INITIAL_STEP: r_cfg_step <= i_cfg_data[StepCfgW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1   <= '0;
            r_h2   <= '0;
            r_tap  <= '0;
            r_step <= AccW'(InitialStepReset);
        end else begin
            if (i_cmd.load && i_restart) begin
                r_h1   <= '0;
                r_h2   <= '0;
                r_tap  <= '0;
                r_step <= AccW'(r_cfg_step);
            end
            if (i_cmd.mul) begin
                r_tap <= w_tap_next;
            end
            if (i_cmd.upd) begin
                r_h2   <= r_h1;
                r_h1   <= w_pred;
                r_step <= w_step_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte  <= i_code_byte;
            r_final <= i_final_byte;
        end
        if (i_cmd.mul) begin
            r_prod_pred <= w_pp_full[AccW-1:0];
            r_prod_step <= w_ps_full[AccW-1:0];
        end
        if (i_cmd.upd) begin
            if (i_cmd.nib_sel) r_s1 <= w_sample;
            else               r_s0 <= w_sample;
        end
        if (i_cmd.emit) begin
            o_sample_first  <= r_s0;
            o_sample_second <= r_s1;
            o_final_res     <= r_final;
        end
    end

endmodule

// ----- rtl/adpcm4_ctrl.sv -----
// adpcm4_ctrl: sequencer for the two nibble decodes and the output slot
// depends on adpcm4_pkg; commands adpcm4_dp through t_dp_cmd
`timescale 1ns / 1ps

module adpcm4_ctrl
    import adpcm4_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL0 = 6'b000010,
        S_UPD0 = 6'b000100,
        S_MUL1 = 6'b001000,
        S_UPD1 = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL0;
                end
            end
            S_MUL0: begin
                o_cmd.mul = 1'b1;
                n_state   = S_UPD0;
            end
            S_UPD0: begin
                o_cmd.upd = 1'b1;
                n_state   = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul     = 1'b1;
                o_cmd.nib_sel = 1'b1;
                n_state       = S_UPD1;
            end
            S_UPD1: begin
                o_cmd.upd     = 1'b1;
                o_cmd.nib_sel = 1'b1;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) n_out_valid = 1'b0;
        if (o_cmd.emit)  n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_onehot_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote a pending result");

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_MUL0))
        else $error("accepted request did not start decoding");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_out_valid && r_state == S_IDLE))
        else $error("emitted result not presented");
`endif

endmodule

// ----- rtl/adpcm4_second_order_decoder.sv -----
// adpcm4_second_order_decoder: top level of the 4-bit adpcm decoder
// depends on adpcm4_pkg, adpcm4_in_if, adpcm4_out_if, adpcm4_ctrl, adpcm4_dp
`timescale 1ns / 1ps

// one request carries a code byte holding two 4-bit signed codes, low nibble
// decoded first; each request yields one result with two clamped 8-bit samples
// and a copy of the end-of-stream flag. a request with restart set clears the
// history and tap and loads initial_step before its byte is decoded. the block
// takes one request at a time: a request is accepted in the idle state, each
// nibble then passes through the shared multiply and update steps, and the
// emit step moves the samples into the output register; only then is a new
// request taken. the output register holds a finished result while the next
// request is decoded; if it is still full when that one finishes, the
// sequencer waits in its emit step.
// configuration writes take effect at once and are meant for idle periods.

module adpcm4_second_order_decoder
    import adpcm4_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    adpcm4_in_if.sink           i_in,
    adpcm4_out_if.source        o_out,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    // command word from the sequencer to the datapath
    t_dp_cmd w_cmd;

    // sequencer: request handshake, nibble steps and the result valid flag
    adpcm4_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    // datapath: predictor state, step adaptation, clamp and result payload
    adpcm4_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_code_byte     (i_in.code_byte),
        .i_restart       (i_in.restart),
        .i_final_byte    (i_in.final_byte),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_sample_first  (o_out.sample_first),
        .o_sample_second (o_out.sample_second),
        .o_final_res     (o_out.final_res)
    );

endmodule

// ----- sim/adpcm4_decode_monitor.sv -----
// adpcm4_decode_monitor: watches the request, result and register ports of the decoder,
// predicts every result and compares it; depends on adpcm4_pkg, adpcm4_in_if, adpcm4_out_if
`timescale 1ns / 1ps

module adpcm4_decode_monitor
    import adpcm4_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    adpcm4_in_if                i_in,
    adpcm4_out_if               i_out,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output int                  o_err_count,
    output int                  o_pending,
    output int                  o_checked
);

    localparam int          TAP_LEAK_SHIFT = 3;
    localparam int          TAP_OUT_SHIFT  = 8;
    localparam int          STEP_SHIFT     = 7;
    localparam logic [31:0] STEP_ROUND     = 32'd127;
    localparam int          MAX_PRINTED    = 40;

    localparam logic [31:0] STEP_GAIN [16] = '{
        32'd112, 32'd128, 32'd128, 32'd128, 32'd128, 32'd136, 32'd136, 32'd192,
        32'd192, 32'd192, 32'd136, 32'd136, 32'd128, 32'd128, 32'd128, 32'd128
    };

    typedef struct packed {
        logic [SampleW-1:0] first;
        logic [SampleW-1:0] second;
        logic               final_flag;
    } t_pcm_pair;

    logic [31:0]        hist_one;
    logic [31:0]        hist_two;
    logic [31:0]        leaky_tap;
    logic [31:0]        step_size;
    logic [SampleW-1:0] clamp_lo;
    logic [SampleW-1:0] clamp_hi;
    logic [15:0]        restart_step;

    t_pcm_pair expected_pairs[$];

    task automatic report_mismatch(input string msg);
        if (o_err_count < MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        o_err_count++;
    endtask

    task automatic decode_nibble(input logic [3:0] code, output logic [SampleW-1:0] pcm);
        logic signed [31:0] leak;
        logic [31:0]        code_ext;
        logic [31:0]        predicted;
        logic [31:0]        step_prod;
        int                 level;
        leak      = $signed(leaky_tap) >>> TAP_LEAK_SHIFT;
        leaky_tap = hist_two + leaky_tap - leak;
        level     = $signed(leaky_tap) >>> TAP_OUT_SHIFT;
        // low bound wins when the bounds are inverted
        if (level < $signed(clamp_lo)) begin
            level = $signed(clamp_lo);
        end else if (level > $signed(clamp_hi)) begin
            level = $signed(clamp_hi);
        end
        pcm       = level[SampleW-1:0];
        code_ext  = {{28{code[3]}}, code};
        predicted = code_ext * step_size + (hist_one - hist_two);
        hist_two  = hist_one;
        hist_one  = predicted;
        step_prod = step_size * STEP_GAIN[code] + STEP_ROUND;
        step_size = $signed(step_prod) >>> STEP_SHIFT;
    endtask

    task automatic decode_request(input logic [7:0] code_byte, input logic restart,
                                  input logic final_flag);
        t_pcm_pair pair;
        if (restart) begin
            hist_one  = '0;
            hist_two  = '0;
            leaky_tap = '0;
            step_size = {16'd0, restart_step};
        end
        decode_nibble(code_byte[3:0], pair.first);
        decode_nibble(code_byte[7:4], pair.second);
        pair.final_flag = final_flag;
        expected_pairs.push_back(pair);
    endtask

    initial begin
        o_err_count = 0;
        o_checked   = 0;
        o_pending   = 0;
    end

    always @(posedge i_clk) begin : watch
        t_pcm_pair want;
        if (!i_rst_n) begin
            hist_one     = '0;
            hist_two     = '0;
            leaky_tap    = '0;
            step_size    = 32'h0000_0800;
            clamp_lo     = 8'h80;
            clamp_hi     = 8'h7F;
            restart_step = 16'h0800;
            expected_pairs.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SAMPLE_MIN:   clamp_lo     = i_cfg_data[SampleW-1:0];
                    CFG_SAMPLE_MAX:   clamp_hi     = i_cfg_data[SampleW-1:0];
                    CFG_INITIAL_STEP: restart_step = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // results first, so a result never meets the request of the same edge
            if (i_out.valid && i_out.ready) begin
                o_checked++;
                if (expected_pairs.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              o_checked));
                end else begin
                    want = expected_pairs.pop_front();
                    if (i_out.sample_first !== want.first ||
                        i_out.sample_second !== want.second ||
                        i_out.final_res !== want.final_flag) begin
                        report_mismatch($sformatf(
                            "result %0d got %0d %0d final %b, want %0d %0d final %b",
                            o_checked, $signed(i_out.sample_first),
                            $signed(i_out.sample_second), i_out.final_res,
                            $signed(want.first), $signed(want.second), want.final_flag));
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                decode_request(i_in.code_byte, i_in.restart, i_in.final_byte);
            end
        end
        o_pending <= expected_pairs.size();
    end

endmodule

// ----- sim/adpcm4_second_order_decoder_tb.sv -----
// adpcm4_second_order_decoder_tb: top of the decoder testbench, makes requests, register
// writes and result stalls and gives the verdict; depends on the rtl and adpcm4_decode_monitor
`timescale 1ns / 1ps

module adpcm4_second_order_decoder_tb;
    import adpcm4_pkg::*;

    // index 3 is not a register; writes to it must be dropped
    localparam logic [CfgIdxW-1:0] CFG_UNUSED_IDX = 2'd3;

    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int SETTLE_CYCLES   = 12;
    localparam int QUIET_LIMIT     = 4000;

    // idle profiles, one per phase in turn
    localparam int IDLE_NONE     = 0;
    localparam int IDLE_SENDER   = 1;
    localparam int IDLE_RECEIVER = 2;
    localparam int IDLE_BOTH     = 3;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_idx;
    logic [CfgDataW-1:0] cfg_data;

    int err_count;
    int pending;
    int checked;

    int sender_idle_pct;
    int receiver_stall_pct;
    int quiet_cycles;
    int n_requests;
    int n_restarts;
    int n_finals;
    int n_phases;

    adpcm4_in_if  in_ch ();
    adpcm4_out_if out_ch ();

    adpcm4_second_order_decoder DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    adpcm4_decode_monitor u_monitor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_err_count (err_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side: ready drops at random by the current stall rate
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // watchdog: too long without any request or result moving ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no request or result for %0d cycles", QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idle_profile(input int profile);
        sender_idle_pct    = (profile == IDLE_SENDER)   ? 51 :
                             (profile == IDLE_BOTH)     ? 27 : 0;
        receiver_stall_pct = (profile == IDLE_RECEIVER) ? 51 :
                             (profile == IDLE_BOTH)     ? 27 : 0;
    endtask

    // one register per cycle; upper data bits of the bound writes carry noise that must be ignored
    task automatic set_config(input int lo, input int hi, input int init_step);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SAMPLE_MIN;
        cfg_data <= {8'($urandom), 8'(lo)};
        @(posedge i_clk);
        cfg_idx  <= CFG_SAMPLE_MAX;
        cfg_data <= {8'($urandom), 8'(hi)};
        @(posedge i_clk);
        cfg_idx  <= CFG_INITIAL_STEP;
        cfg_data <= 16'(init_step);
        @(posedge i_clk);
        cfg_idx  <= CFG_UNUSED_IDX;
        cfg_data <= 16'($urandom);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        n_phases++;
    endtask

    // valid is only touched once per edge: lowered during a gap, raised for the request
    task automatic send_request(input logic [7:0] code_byte, input logic restart,
                                input logic final_flag);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.code_byte  <= code_byte;
        in_ch.restart    <= restart;
        in_ch.final_byte <= final_flag;
        do @(posedge i_clk); while (!in_ch.ready);
        n_requests++;
        n_restarts += restart;
        n_finals   += final_flag;
    endtask

    // hold off requests until every predicted result has been seen
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic settle();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly well formed streams: restart on the first byte, end marker on the last;
    // some bytes are noise with random flags, which also breaks streams apart
    task automatic run_streams(input int n_items);
        int          sent;
        int          left;
        logic        restart;
        logic        final_flag;
        logic [7:0]  code_byte;
        sent = 0;
        left = 0;
        while (sent < n_items) begin
            if (sent == n_items / 2) begin
                wait_for_results();
            end
            if ($urandom_range(15) == 0) begin
                code_byte  = 8'($urandom);
                restart    = 1'($urandom);
                final_flag = 1'($urandom);
            end else begin
                restart = (left == 0);
                if (left == 0) begin
                    // a few long streams let the step run away and wrap
                    left = ($urandom_range(7) == 0) ? $urandom_range(60, 120)
                                                    : $urandom_range(1, 24);
                end
                left--;
                final_flag = (left == 0);
                // repeated big codes push the step up fast
                if ($urandom_range(5) == 0) begin
                    code_byte = {2{4'($urandom_range(7, 9))}};
                end else begin
                    code_byte = 8'($urandom);
                end
            end
            send_request(code_byte, restart, final_flag);
            sent++;
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= CFG_SAMPLE_MIN;
        cfg_data         <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.code_byte  <= '0;
        in_ch.restart    <= 1'b0;
        in_ch.final_byte <= 1'b0;
        n_requests = 0;
        n_restarts = 0;
        n_finals   = 0;
        n_phases   = 0;
        set_idle_profile(IDLE_NONE);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full range bounds, every code, extreme bytes, short streams
        set_config(-128, 127, 2048);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'h77, 1'b0, 1'b0);
        send_request(8'h88, 1'b0, 1'b0);
        send_request(8'h10, 1'b0, 1'b0);
        send_request(8'h32, 1'b0, 1'b0);
        send_request(8'h54, 1'b0, 1'b0);
        send_request(8'h76, 1'b0, 1'b0);
        send_request(8'h98, 1'b0, 1'b0);
        send_request(8'hBA, 1'b0, 1'b0);
        send_request(8'hDC, 1'b0, 1'b0);
        send_request(8'hFE, 1'b0, 1'b0);
        send_request(8'hFF, 1'b0, 1'b0);
        send_request(8'h0F, 1'b0, 1'b0);
        send_request(8'hF0, 1'b0, 1'b0);
        send_request(8'h80, 1'b0, 1'b1);
        send_request(8'h08, 1'b1, 1'b1);
        send_request(8'h7F, 1'b1, 1'b0);
        settle();

        // inverted bounds with a zero restart step: everything sits at the low bound
        set_config(20, -20, 0);
        send_request(8'h77, 1'b1, 1'b0);
        send_request(8'h9E, 1'b0, 1'b0);
        send_request(8'h18, 1'b0, 1'b1);
        settle();

        // narrow inverted bounds with a moving decoder
        set_config(5, -5, 300);
        send_request(8'h34, 1'b1, 1'b0);
        send_request(8'hC7, 1'b0, 1'b0);
        send_request(8'h2B, 1'b0, 1'b0);
        send_request(8'hF1, 1'b0, 1'b1);
        settle();

        // random phases, cycling through the idle profiles
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_idle_profile(p % 4);
            case (p)
                0:       set_config(-128, 127, 2048);
                1:       set_config(-128, 127, 65535);
                2:       set_config(-100, 90, 1);
                3:       set_config(127, -128, 700);
                4:       set_config(-30, 100, $urandom_range(1, 4096));
                default: set_config(int'($urandom_range(255)) - 128,
                                    int'($urandom_range(255)) - 128,
                                    $urandom_range(65535));
            endcase
            run_streams(ITEMS_PER_PHASE);
            settle();
        end

        $display("covered %0d requests (%0d restarts, %0d end markers) in %0d settings",
                 n_requests, n_restarts, n_finals, n_phases);
        $display("compared %0d results, %0d mismatches", checked, err_count);
        if (err_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
